// ===== design/rtp_pkg.sv =====
package rtp_pkg;

  // Sizes
  localparam int VALUE_WIDTH_DEFAULT = 64;
  localparam int OUT_WIDTH           = 64;
  localparam int RADIX_W             = 6;
  localparam int QUEUE_DEPTH         = 4;

  // Radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DECIMAL     = 6'd10;

  // Digit code for a byte that is no digit at all (never below any radix)
  localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'd63;

  // Character codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] LETTER_BASE = 8'd10;

  // Configuration register indexes
  localparam logic [1:0] CFG_RADIX  = 2'd0;
  localparam logic [1:0] CFG_SIGNED = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_BADCHAR  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Class of a text byte as decided by the front end
  typedef enum logic [2:0] {
    K_NONE,
    K_PLUS,
    K_MINUS,
    K_DIGIT,
    K_BAD
  } kind_t;

  // One classified item on its way to the back end
  typedef struct packed {
    kind_t                kind;
    logic [RADIX_W-1:0]   digit;
    logic [RADIX_W-1:0]   base;
    logic                 sgn;
    logic                 last;
  } entry_t;

  // Digit value of a byte: 0-9, then letters of either case from ten up
  function automatic logic [RADIX_W-1:0] char_digit(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + LETTER_BASE;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + LETTER_BASE;
    end else begin
      d = {2'b00, DIGIT_NONE};
    end
    return d[RADIX_W-1:0];
  endfunction

endpackage

// ===== design/radix_integer_text_parser.sv =====
// Parses one integer from a byte stream, one byte per item, the final item
// marked by last_char; that item yields one result (value and status). The
// front end takes one item per clock into a four-entry queue while the queue
// is not full. The back end reads a byte from the queue only in S_IDLE, where
// it registers a VALUE_WIDTH x 6 multiply; S_EXEC then adds the digit and
// compares with the limit, and after the last item S_FIN posts the result;
// the queue absorbs short bursts. A single result register sits on the
// output; while a result waits there the back end keeps parsing, and it
// stalls only once the next text is complete, after which input stops when
// the queue fills. Configuration writes apply to items accepted after the
// write; the block has no clearing pass after reset.
module radix_integer_text_parser import rtp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [5:0]           cfg_data,
  // input items
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           char_in,
  input  logic                 has_char,
  input  logic                 last_char,
  // result items
  output logic                 empty,
  input  logic                 pop,
  output logic [OUT_WIDTH-1:0] parsed_value,
  output logic [1:0]           parse_status
);

  logic                   q_wr;
  logic                   q_rd;
  logic                   q_full;
  logic                   q_empty;
  entry_t                 q_in;
  entry_t                 q_out;
  logic                   out_valid;
  logic [VALUE_WIDTH-1:0] out_value;

  assign cfg_ready    = 1'b1;
  assign full         = q_full;
  assign empty        = !out_valid;
  assign parsed_value = OUT_WIDTH'(out_value);

  rtp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .char_in   (char_in),
    .has_char  (has_char),
    .last_char (last_char),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_data    (q_in)
  );

  rtp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_in),
    .rd_en   (q_rd),
    .rd_data (q_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  rtp_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_rd       (q_rd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .out_status (parse_status)
  );

endmodule

// ===== design/rtp_front.sv =====
module rtp_front import rtp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr,
  input  logic [1:0]   cfg_index,
  input  logic [5:0]   cfg_data,
  input  logic         push,
  input  logic [7:0]   char_in,
  input  logic         has_char,
  input  logic         last_char,
  input  logic         q_full,
  output logic         q_wr,
  output entry_t       q_data
);

  logic [RADIX_W-1:0] radix;
  logic               signed_mode;
  logic               at_first;
  logic               accept;
  logic [RADIX_W-1:0] base;
  logic [RADIX_W-1:0] digit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      signed_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_RADIX:  radix       <= cfg_data;
        CFG_SIGNED: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective base: decimal in signed mode, radix clamped to 2..36 otherwise
  always_comb begin
    if (signed_mode)            base = DECIMAL;
    else if (radix < RADIX_MIN) base = RADIX_MIN;
    else if (radix > RADIX_MAX) base = RADIX_MAX;
    else                        base = radix;
  end

  assign digit  = char_digit(char_in);
  assign accept = push && !q_full;
  // items with neither a byte nor the last mark leave no trace
  assign q_wr   = accept && (has_char || last_char);

  // Classify the byte
  always_comb begin
    q_data.digit = digit;
    q_data.base  = base;
    q_data.sgn   = signed_mode;
    q_data.last  = last_char;
    if (!has_char) begin
      q_data.kind = K_NONE;
    end else if (at_first && char_in == CH_PLUS) begin
      q_data.kind = K_PLUS;
    end else if (at_first && signed_mode && char_in == CH_MINUS) begin
      q_data.kind = K_MINUS;
    end else if (digit < base) begin
      q_data.kind = K_DIGIT;
    end else begin
      q_data.kind = K_BAD;
    end
  end

  // Start-of-text tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      at_first <= 1'b1;
    end else if (accept) begin
      if (last_char)     at_first <= 1'b1;
      else if (has_char) at_first <= 1'b0;
    end
  end

endmodule

// ===== design/rtp_queue.sv =====
module rtp_queue import rtp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_data,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en)      count <= count + CNT_W'(1);
      else if (rd_en && !wr_en) count <= count - CNT_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) rd_en |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule

// ===== design/rtp_back.sv =====
module rtp_back import rtp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  entry_t                 q_data,
  output logic                   q_rd,
  input  logic                   pop,
  output logic                   out_valid,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic [1:0]             out_status
);

  localparam int PW = VALUE_WIDTH + RADIX_W;
  localparam int SW = PW + 1;
  localparam logic [SW-1:0] UNSIGNED_MAX = SW'({VALUE_WIDTH{1'b1}});
  localparam logic [SW-1:0] SIGNED_MAG   = SW'(1) << (VALUE_WIDTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  state_t                 state;
  entry_t                 cur;
  logic [PW-1:0]          prod;
  logic [VALUE_WIDTH-1:0] acc;
  logic                   neg;
  logic                   seen;
  logic [1:0]             err;

  logic [SW-1:0]          sum;
  logic [SW-1:0]          limit;
  logic                   over;
  logic                   out_free;
  logic [1:0]             fin_status;
  logic [VALUE_WIDTH-1:0] fin_value;

  assign q_rd = (state == S_IDLE) && !q_empty;

  // Add digit and check against the mode's limit
  assign sum   = SW'(prod) + SW'(cur.digit);
  assign limit = cur.sgn ? (SIGNED_MAG - SW'(!neg)) : UNSIGNED_MAX;
  assign over  = (sum > limit);

  assign out_free = !out_valid || pop;

  // Final status and value
  always_comb begin
    if (err != ST_OK) fin_status = err;
    else if (!seen)   fin_status = ST_EMPTY;
    else              fin_status = ST_OK;
    if (fin_status != ST_OK)  fin_value = '0;
    else if (cur.sgn && neg)  fin_value = (~acc) + VALUE_WIDTH'(1);
    else                      fin_value = acc;
  end

  // Sequencer: multiply, then add/compare, then post a result on the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      neg       <= 1'b0;
      seen      <= 1'b0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      // the finish state reloads the result register itself
      if (out_valid && pop && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_data;
            prod  <= PW'(acc) * PW'(q_data.base);
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // first error sticks until the end of the text
          if (err == ST_OK) begin
            unique case (cur.kind) inside
              K_PLUS, K_MINUS: neg <= (cur.kind == K_MINUS);
              K_BAD:           err <= ST_BADCHAR;
              K_DIGIT: begin
                if (over) begin
                  err <= ST_OVERFLOW;
                end else begin
                  acc  <= sum[VALUE_WIDTH-1:0];
                  seen <= 1'b1;
                end
              end
              default: ;
            endcase
          end
          state <= cur.last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_value  <= fin_value;
            out_status <= fin_status;
            acc        <= '0;
            neg        <= 1'b0;
            seen       <= 1'b0;
            err        <= ST_OK;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_err_zero_value: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_status != ST_OK) |-> (out_value == '0))
    else $error("error result carries a nonzero value");
  a_acc_needs_digit: assert property (@(posedge clk) disable iff (rst)
      !seen |-> (acc == '0))
    else $error("accumulator moved without a digit");
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
      (err != ST_OK && state != S_FIN) |=> (err == $past(err)))
    else $error("error code changed before the end of the text");
`endif

endmodule

// ===== sim/tb_radix_integer_text_parser.sv =====
module tb_radix_integer_text_parser;
  import rtp_pkg::*;

  localparam int TEXT_ITEMS  = 1400;
  localparam int QUIET_CYC   = 24;
  localparam int STALL_LIMIT = 2000;
  localparam logic [63:0] SIGNED_TOP = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [7:0] c;
    logic       h;
    logic       l;
  } text_byte_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } parse_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  c;
    logic        h;
    logic        l;
    logic [1:0]  idx;
    logic [5:0]  data;
    logic        pin;
    logic [1:0]  st;
    logic [63:0] v;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;
  logic        push;
  logic        full;
  logic [7:0]  char_in;
  logic        has_char;
  logic        last_char;
  logic        empty;
  logic        pop;
  logic [63:0] parsed_value;
  logic [1:0]  parse_status;

  // shadow of the parser: registers and text state
  logic [5:0]  cfg_radix;
  logic        cfg_signed;
  logic [63:0] acc;
  logic        at_first;
  logic        neg;
  logic        seen;
  logic [1:0]  err;

  parse_result_t pending_results[$];
  row_t          directed_rows[$];

  // expectation typed into a directed row, carried with its item
  logic          pin_on;
  parse_result_t pin_result;

  int  items_taken;
  int  errors;
  bit  idle_on;

  radix_integer_text_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .char_in      (char_in),
    .has_char     (has_char),
    .last_char    (last_char),
    .empty        (empty),
    .pop          (pop),
    .parsed_value (parsed_value),
    .parse_status (parse_status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int active_base();
    if (cfg_signed) return 10;
    if (cfg_radix < 2) return 2;
    if (cfg_radix > 36) return 36;
    return int'(cfg_radix);
  endfunction

  // 255 for a byte that is no digit in any radix
  function automatic logic [63:0] digit_value(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 64'(c - CH_0);
    if (c >= CH_LA && c <= CH_LZ) return 64'(c - CH_LA) + 64'd10;
    if (c >= CH_UA && c <= CH_UZ) return 64'(c - CH_UA) + 64'd10;
    return 64'd255;
  endfunction

  function automatic void clear_text();
    acc      = '0;
    at_first = 1'b1;
    neg      = 1'b0;
    seen     = 1'b0;
    err      = ST_OK;
  endfunction

  function automatic void accumulate_char(logic [7:0] c);
    logic        first;
    logic [63:0] base;
    logic [63:0] d;
    logic [63:0] lim;
    first    = at_first;
    at_first = 1'b0;
    // first error sticks until the end of the text
    if (err != ST_OK) return;
    if (first && (c == CH_PLUS || (c == CH_MINUS && cfg_signed))) begin
      neg = (c == CH_MINUS);
      return;
    end
    base = 64'(active_base());
    d    = digit_value(c);
    if (d >= base) begin
      err = ST_BADCHAR;
      return;
    end
    lim = cfg_signed ? (SIGNED_TOP - (neg ? 64'd0 : 64'd1)) : '1;
    if (acc > (lim - d) / base) begin
      err = ST_OVERFLOW;
      return;
    end
    acc  = acc * base + d;
    seen = 1'b1;
  endfunction

  function automatic parse_result_t close_text();
    parse_result_t r;
    if (err != ST_OK) r.status = err;
    else if (!seen) r.status = ST_EMPTY;
    else r.status = ST_OK;
    r.value = '0;
    if (r.status == ST_OK) r.value = (cfg_signed && neg) ? -acc : acc;
    clear_text();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    parse_result_t r;
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: parsed_value %h parse_status %0d",
                 parsed_value, parse_status);
          errors++;
        end else begin
          r = pending_results.pop_front();
          if (parsed_value !== r.value) begin
            $error("parsed_value: expected %h, actual %h", r.value, parsed_value);
            errors++;
          end
          if (parse_status !== r.status) begin
            $error("parse_status: expected %0d, actual %0d", r.status, parse_status);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RADIX:  cfg_radix  = cfg_data;
          CFG_SIGNED: cfg_signed = cfg_data[0];
          default: ;
        endcase
      end
      if (push && !full) begin
        if (has_char || last_char) items_taken++;
        if (has_char) accumulate_char(char_in);
        if (last_char) begin
          r = close_text();
          if (pin_on) r = pin_result;
          pending_results.push_back(r);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls
  // ---------------------------------------------------------------------------

  initial begin
    int gap;
    pop = 1'b0;
    forever begin
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      @(posedge clk);
      while (empty || rst) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no handshake at all
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        stall = 0;
      else
        stall++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------

  task automatic drive_item(input logic [7:0] c, input logic h, input logic l,
                            input logic pin, input parse_result_t pin_r);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_in    = c;
    has_char   = h;
    last_char  = l;
    pin_on     = pin;
    pin_result = pin_r;
    push       = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every result is back and the back end has drained
  task automatic settle();
    push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (QUIET_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return CH_0 + 8'(d);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10);
  endfunction

  function automatic int max_digits(int base);
    logic [63:0] v;
    int n;
    v = '1;
    n = 0;
    while (v != 0) begin
      v = v / 64'(base);
      n++;
    end
    return n;
  endfunction

  task automatic render(input logic [63:0] v, input int base, ref text_byte_t txt[$]);
    text_byte_t tmp[$];
    do begin
      tmp.push_front('{digit_char(int'(v % 64'(base))), 1'b1, 1'b0});
      v = v / 64'(base);
    end while (v != 0);
    if ($urandom_range(0, 5) == 0) txt.push_back('{CH_0, 1'b1, 1'b0});
    foreach (tmp[i]) txt.push_back(tmp[i]);
  endtask

  task automatic add_digits(input int n, input int base, ref text_byte_t txt[$]);
    for (int i = 0; i < n; i++)
      txt.push_back('{digit_char($urandom_range(0, base - 1)), 1'b1, 1'b0});
  endtask

  task automatic send_random_text(input bit finish);
    text_byte_t  txt[$];
    int          base;
    int          len;
    int          kind;
    int          d;
    logic        minus;
    logic [63:0] lim;
    logic [7:0]  c;
    base  = active_base();
    minus = cfg_signed && $urandom_range(0, 1);
    lim   = cfg_signed ? (SIGNED_TOP - (minus ? 64'd0 : 64'd1)) : '1;
    if (minus) txt.push_back('{CH_MINUS, 1'b1, 1'b0});
    else if ($urandom_range(0, 3) == 0) txt.push_back('{CH_PLUS, 1'b1, 1'b0});
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        len = $urandom_range(0, 1) ? $urandom_range(1, 4)
                                   : $urandom_range(1, max_digits(base) + 1);
        if ($urandom_range(0, 3) == 0) begin
          txt.push_back('{digit_char(base - 1), 1'b1, 1'b0});
          len = len - 1;
        end
        add_digits(len, base, txt);
      end
      4, 5: begin
        // right at the limit: last digit decides between fit and overflow
        render(lim / 64'(base), base, txt);
        case ($urandom_range(0, 2))
          0: d = int'(lim % 64'(base));
          1: d = int'(lim % 64'(base)) + 1;
          default: d = $urandom_range(0, base - 1);
        endcase
        if (d >= base) d = base - 1;
        txt.push_back('{digit_char(d), 1'b1, 1'b0});
      end
      6: begin
        render(lim, base, txt);
      end
      7: begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 5))
            0: c = CH_PLUS;
            1: c = CH_MINUS;
            2: c = digit_char($urandom_range(0, 35));
            default: c = 8'($urandom_range(0, 255));
          endcase
          txt.push_back('{c, 1'($urandom_range(0, 5) != 0), 1'b0});
        end
      end
      8: begin
        add_digits($urandom_range(1, 4), base, txt);
        c = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? CH_PLUS : CH_MINUS)
                                 : 8'($urandom_range(0, 255));
        txt.push_back('{c, 1'b1, 1'b0});
        add_digits($urandom_range(1, 4), base, txt);
      end
      default: ;
    endcase
    if (finish) begin
      if (txt.size() == 0 || $urandom_range(0, 3) == 0)
        txt.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
      else
        txt[txt.size() - 1].l = 1'b1;
    end
    foreach (txt[i]) begin
      // items with neither byte nor end mark are dropped by the parser
      if ($urandom_range(0, 9) == 0)
        drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
      drive_item(txt[i].c, txt[i].h, txt[i].l, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------

  function automatic row_t item_row(logic [7:0] c, logic h, logic l);
    row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.c    = c;
    r.h    = h;
    r.l    = l;
    return r;
  endfunction

  function automatic row_t pinned(logic [7:0] c, logic h, logic [1:0] st, logic [63:0] v);
    row_t r;
    r     = item_row(c, h, 1'b1);
    r.pin = 1'b1;
    r.st  = st;
    r.v   = v;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, logic [5:0] data);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  initial begin
    // defaults after reset: radix 10, unsigned
    directed_rows.push_back(pinned(8'h00, 1'b0, ST_EMPTY, '0));      // empty text
    directed_rows.push_back(pinned("0", 1'b1, ST_OK, '0));
    directed_rows.push_back(pinned(CH_PLUS, 1'b1, ST_EMPTY, '0));    // sign only
    directed_rows.push_back(pinned(CH_MINUS, 1'b1, ST_BADCHAR, '0)); // minus, unsigned
    directed_rows.push_back(item_row("1", 1'b1, 1'b0));              // late sign
    directed_rows.push_back(pinned(CH_PLUS, 1'b1, ST_BADCHAR, '0));
    directed_rows.push_back(item_row(8'hA5, 1'b0, 1'b0));            // ignored item
    directed_rows.push_back(item_row("9", 1'b1, 1'b1));
    directed_rows.push_back(item_row("/", 1'b1, 1'b0));              // first error kept
    directed_rows.push_back(pinned("5", 1'b1, ST_BADCHAR, '0));
    directed_rows.push_back(pinned(8'hFF, 1'b1, ST_BADCHAR, '0));
    directed_rows.push_back(pinned(8'h00, 1'b1, ST_BADCHAR, '0));
    directed_rows.push_back(cfg_row(CFG_RADIX, 6'd36));
    directed_rows.push_back(item_row("z", 1'b1, 1'b0));
    directed_rows.push_back(item_row("Z", 1'b1, 1'b1));
    directed_rows.push_back(pinned("@", 1'b1, ST_BADCHAR, '0));
    directed_rows.push_back(pinned("{", 1'b1, ST_BADCHAR, '0));
    directed_rows.push_back(cfg_row(CFG_RADIX, 6'd63));               // clamps to 36
    directed_rows.push_back(item_row("Y", 1'b1, 1'b1));
    directed_rows.push_back(cfg_row(CFG_RADIX, 6'd0));                // clamps to 2
    directed_rows.push_back(item_row("1", 1'b1, 1'b0));
    directed_rows.push_back(pinned("2", 1'b1, ST_BADCHAR, '0));
    directed_rows.push_back(cfg_row(CFG_SIGNED, 6'd1));
    directed_rows.push_back(item_row(CH_MINUS, 1'b1, 1'b0));
    directed_rows.push_back(item_row("9", 1'b1, 1'b1));
    directed_rows.push_back(pinned(CH_MINUS, 1'b1, ST_EMPTY, '0));
    directed_rows.push_back(item_row(CH_PLUS, 1'b1, 1'b0));
    directed_rows.push_back(pinned(CH_MINUS, 1'b1, ST_BADCHAR, '0));
    // mode and radix change in the middle of a text
    directed_rows.push_back(item_row("4", 1'b1, 1'b0));
    directed_rows.push_back(cfg_row(CFG_SIGNED, 6'd0));
    directed_rows.push_back(cfg_row(CFG_RADIX, 6'd16));
    directed_rows.push_back(item_row("f", 1'b1, 1'b1));
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    parse_result_t r;
    logic [5:0]    rdx;
    int            n;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_RADIX;
    cfg_data    = '0;
    push        = 1'b0;
    char_in     = '0;
    has_char    = 1'b0;
    last_char   = 1'b0;
    pin_on      = 1'b0;
    pin_result  = '0;
    items_taken = 0;
    errors      = 0;
    idle_on     = 1'b1;
    cfg_radix   = RADIX_RESET;
    cfg_signed  = 1'b0;
    clear_text();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        r.value  = directed_rows[i].v;
        r.status = directed_rows[i].st;
        drive_item(directed_rows[i].c, directed_rows[i].h, directed_rows[i].l,
                   directed_rows[i].pin, r);
      end
    end

    // random part: each phase drains the parser, then picks new settings
    while (items_taken < TEXT_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0: rdx = RADIX_MIN;
        1: rdx = RADIX_MAX;
        2: rdx = 6'($urandom_range(0, 1));
        3: rdx = 6'($urandom_range(37, 63));
        default: rdx = 6'($urandom_range(2, 36));
      endcase
      write_reg(CFG_RADIX, rdx);
      write_reg(CFG_SIGNED, {5'($urandom_range(0, 31)), 1'($urandom_range(0, 2) == 0)});
      idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(4, 12);
      // a phase may end mid-text so the next settings apply to its tail
      for (int i = 0; i < n; i++)
        send_random_text(i < n - 1 || $urandom_range(0, 4) != 0);
    end
    drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
    settle();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
